// ===== sv/rccr_pkg.sv =====
// shared types, constants and the rank decoder for the rank chain crosspoint router
// no dependencies
`default_nettype none

package rccr_pkg;

    localparam int SLOTS       = 8;
    localparam int RANK_W      = 3;
    localparam int RANKS       = 1 << RANK_W;
    localparam int IO_LINE     = 7;
    localparam int SEARCH_SPAN = 5;
    localparam int MASK_W      = SLOTS * SLOTS;

    typedef struct packed {
        logic [RANK_W-1:0] rank_slot0;
        logic [RANK_W-1:0] rank_slot1;
        logic [RANK_W-1:0] rank_slot2;
        logic [RANK_W-1:0] rank_slot3;
        logic [RANK_W-1:0] rank_slot4;
        logic [RANK_W-1:0] rank_slot5;
        logic [RANK_W-1:0] rank_slot6;
        logic [RANK_W-1:0] rank_slot7;
    } item_t;

    typedef struct packed {
        logic [MASK_W-1:0] connect_mask;
        logic              bypass;
    } result_t;

    typedef logic [RANKS-1:0]            rank_oh_t;
    typedef rank_oh_t [SLOTS-1:0]        slot_oh_t;
    typedef logic [RANKS-1:0][RANKS-1:0] link_t;

    // chain summary passed from the merge stage to the lanes
    typedef struct packed {
        logic     any;
        rank_oh_t first;
        rank_oh_t last;
        link_t    link;
    } chain_t;

    function automatic rank_oh_t rank_onehot(input logic [RANK_W-1:0] rank);
        rank_oh_t oh;
        oh       = '0;
        oh[rank] = 1'b1;
        return oh;
    endfunction

endpackage

`default_nettype wire

// ===== sv/rank_chain_crosspoint_router_unit.sv =====
// top level of the rank chain crosspoint router: two-stage pipeline around the lanes
// depends on rccr_pkg, rccr_merge and rccr_lane
`default_nettype none

// Takes eight 3-bit slot ranks per beat and returns the 64-bit crosspoint mask
// (bit x*8+y joins line x to line y) plus a bypass flag. One beat is accepted
// every cycle unless the result side stalls; each beat passes the stage-one and
// then the output register. The first stage registers the one-hot decode of each
// rank, the second runs the chain merge and the eight slot lanes into the output
// register. A result-side stall holds both stages and reaches back to item_stall.
module rank_chain_crosspoint_router_unit
    import rccr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    output logic       result_valid,
    input  wire logic  result_stall,
    output result_t    result
);

    logic     s1_valid_reg;
    slot_oh_t s1_oh_reg;
    slot_oh_t s1_oh_next;
    logic     result_valid_reg;
    result_t  result_reg;
    result_t  result_next;
    logic     s2_ready;
    logic     s1_ready;
    chain_t   chain;
    logic [SLOTS-1:0] rows [SLOTS];

    assign s2_ready   = !result_valid_reg || !result_stall;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign item_stall = !s1_ready;

    always_comb
    begin
        s1_oh_next[0] = rank_onehot(item.rank_slot0);
        s1_oh_next[1] = rank_onehot(item.rank_slot1);
        s1_oh_next[2] = rank_onehot(item.rank_slot2);
        s1_oh_next[3] = rank_onehot(item.rank_slot3);
        s1_oh_next[4] = rank_onehot(item.rank_slot4);
        s1_oh_next[5] = rank_onehot(item.rank_slot5);
        s1_oh_next[6] = rank_onehot(item.rank_slot6);
        s1_oh_next[7] = rank_onehot(item.rank_slot7);
    end

    rccr_merge u_merge (
        .slot_oh (s1_oh_reg),
        .chain   (chain)
    );

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_lane
        rccr_lane u_lane (
            .own_oh  (s1_oh_reg[g]),
            .slot_oh (s1_oh_reg),
            .chain   (chain),
            .row     (rows[g])
        );
    end

    always_comb
    begin
        result_next        = '0;
        result_next.bypass = !chain.any;
        for (int i = 0; i < SLOTS; i++)
        begin
            result_next.connect_mask[i*SLOTS +: SLOTS] = rows[i];
        end
        // io line feeds every slot of the first rank
        for (int j = 0; j < SLOTS; j++)
        begin
            result_next.connect_mask[IO_LINE*SLOTS + j] =
                result_next.connect_mask[IO_LINE*SLOTS + j] | (|(s1_oh_reg[j] & chain.first));
        end
        // nothing placed: io line straight through
        result_next.connect_mask[IO_LINE*SLOTS + IO_LINE] =
            result_next.connect_mask[IO_LINE*SLOTS + IO_LINE] | !chain.any;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_ready)
            begin
                result_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && item_valid)
        begin
            s1_oh_reg <= s1_oh_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_oh_reg))
        else $error("stage one beat lost while output stalled");

    a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_ready |=> result_valid_reg)
        else $error("stage one beat not moved to output");

    a_bypass_mask: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.bypass |->
            result_reg.connect_mask == (MASK_W'(1) << (IO_LINE*SLOTS + IO_LINE)))
        else $error("bypass result with stray closures");

    a_io_used: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.bypass |->
            (|result_reg.connect_mask[IO_LINE*SLOTS +: SLOTS]))
        else $error("chain result without an io line feed");
`endif

endmodule

`default_nettype wire

// ===== sv/rccr_merge.sv =====
// merge stage: combines the lane one-hot ranks into presence, chain links, first and last rank
// depends on rccr_pkg
`default_nettype none

module rccr_merge
    import rccr_pkg::*;
(
    input  wire slot_oh_t slot_oh,
    output chain_t        chain
);

    rank_oh_t          present;
    logic              started;
    logic              alive;
    logic [RANK_W-1:0] prev;
    logic [RANK_W-1:0] gap;

    always_comb
    begin
        present = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            present = present | slot_oh[k];
        end
        // rank zero marks an unused slot
        present[0] = 1'b0;

        chain   = '0;
        started = 1'b0;
        alive   = 1'b1;
        prev    = '0;
        gap     = '0;
        for (int r = 1; r < RANKS; r++)
        begin
            gap = RANK_W'(r) - prev;
            if (present[r])
            begin
                if (!started)
                begin
                    started        = 1'b1;
                    chain.first[r] = 1'b1;
                    prev           = RANK_W'(r);
                end
                else if (alive && (gap <= RANK_W'(SEARCH_SPAN)))
                begin
                    chain.link[prev][r] = 1'b1;
                    prev                = RANK_W'(r);
                end
                else
                begin
                    // gap too wide, chain ends at the previous rank
                    alive = 1'b0;
                end
            end
        end
        chain.any = started;
        if (started)
        begin
            chain.last[prev] = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rccr_lane.sv =====
// one slot lane: forms the crosspoint row driven by this slot's line
// depends on rccr_pkg
`default_nettype none

module rccr_lane
    import rccr_pkg::*;
(
    input  wire rank_oh_t    own_oh,
    input  wire slot_oh_t    slot_oh,
    input  wire chain_t      chain,
    output logic [SLOTS-1:0] row
);

    rank_oh_t target;

    always_comb
    begin
        // ranks that this slot's rank feeds
        target = '0;
        for (int s = 0; s < RANKS; s++)
        begin
            for (int r = 0; r < RANKS; r++)
            begin
                target[s] = target[s] | (own_oh[r] & chain.link[r][s]);
            end
        end
        for (int j = 0; j < SLOTS; j++)
        begin
            row[j] = |(target & slot_oh[j]);
        end
        // last reached rank drives the io line
        row[IO_LINE] = row[IO_LINE] | (|(own_oh & chain.last));
    end

endmodule

`default_nettype wire

// ===== tb/rank_chain_crosspoint_router_unit_test.sv =====
// self-checking testbench for rank_chain_crosspoint_router_unit: directed table, then random beats
// depends on rccr_pkg and the rank_chain_crosspoint_router_unit rtl
`default_nettype none

module rank_chain_crosspoint_router_unit_test;
    import rccr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUTE_ITEMS = 1950;

    typedef struct {
        item_t   stim;
        bit      known;
        result_t golden;
    } route_case_t;

    localparam int ROUTE_CASES = 16;

    // ranks written in octal, slot 0 is the leftmost digit
    route_case_t route_cases [ROUTE_CASES] = '{
        '{24'o00000000, 1'b1, {64'h8000_0000_0000_0000, 1'b1}},
        '{24'o77777777, 1'b1, {64'hFF80_8080_8080_8080, 1'b0}},
        '{24'o10000000, 1'b1, {64'h0100_0000_0000_0080, 1'b0}},
        '{24'o00000007, 1'b1, {64'h8000_0000_0000_0000, 1'b0}},
        '{24'o17000000, 1'b1, {64'h0100_0000_0000_0080, 1'b0}},
        '{24'o16000000, 1'b0, '0},
        '{24'o33333333, 1'b1, {64'hFF80_8080_8080_8080, 1'b0}},
        '{24'o12345670, 1'b0, '0},
        '{24'o76543210, 1'b0, '0},
        '{24'o12121212, 1'b0, '0},
        '{24'o00070000, 1'b1, {64'h0800_0000_8000_0000, 1'b0}},
        '{24'o11223344, 1'b0, '0},
        '{24'o17171717, 1'b1, {64'h5580_0080_0080_0080, 1'b0}},
        '{24'o26000000, 1'b0, '0},
        '{24'o57000000, 1'b0, '0},
        '{24'o00000001, 1'b1, {64'h8000_0000_0000_0000, 1'b0}}
    };

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    item_t   item         = '0;
    logic    result_stall = 1'b0;
    logic    item_stall;
    logic    result_valid;
    result_t result;

    result_t pending_routes [$];
    int      mismatches  = 0;
    int      beats_taken = 0;
    int      calm_items  = 0;
    bit      squeezed    = 1'b0;

    rank_chain_crosspoint_router_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic result_t route_ranks(input item_t ranks);
        logic [RANK_W-1:0] r [SLOTS];
        int                lowest;
        int                cur;
        int                nxt;
        bit                any;
        bit                found;
        result_t           res;
        r[0] = ranks.rank_slot0;
        r[1] = ranks.rank_slot1;
        r[2] = ranks.rank_slot2;
        r[3] = ranks.rank_slot3;
        r[4] = ranks.rank_slot4;
        r[5] = ranks.rank_slot5;
        r[6] = ranks.rank_slot6;
        r[7] = ranks.rank_slot7;
        res    = '0;
        any    = 1'b0;
        lowest = RANKS - 1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (r[i] != 0)
            begin
                any = 1'b1;
                if (int'(r[i]) < lowest)
                    lowest = int'(r[i]);
            end
        end
        if (!any)
        begin
            res.connect_mask[IO_LINE*SLOTS + IO_LINE] = 1'b1;
            res.bypass = 1'b1;
            return res;
        end
        for (int i = 0; i < SLOTS; i++)
            if (int'(r[i]) == lowest)
                res.connect_mask[IO_LINE*SLOTS + i] = 1'b1;
        cur   = lowest;
        nxt   = lowest;
        found = 1'b1;
        while (found)
        begin
            found = 1'b0;
            for (int d = 1; d <= SEARCH_SPAN && !found; d++)
                for (int i = 0; i < SLOTS; i++)
                    if (int'(r[i]) == cur + d)
                    begin
                        nxt   = cur + d;
                        found = 1'b1;
                    end
            if (found)
            begin
                for (int j = 0; j < SLOTS; j++)
                    for (int i = 0; i < SLOTS; i++)
                        if (int'(r[j]) == nxt && int'(r[i]) == cur)
                            res.connect_mask[i*SLOTS + j] = 1'b1;
                cur = nxt;
            end
        end
        for (int i = 0; i < SLOTS; i++)
            if (int'(r[i]) == cur)
                res.connect_mask[i*SLOTS + IO_LINE] = 1'b1;
        return res;
    endfunction

    function automatic item_t random_ranks();
        logic [RANK_W-1:0] r [SLOTS];
        int                roll;
        int                step;
        int                rank;
        roll = $urandom_range(0, 99);
        rank = $urandom_range(1, 3);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (roll < 3)
                r[i] = '0;
            else if (roll < 40)
                r[i] = ($urandom_range(0, 99) < 60) ? 3'd0 : 3'($urandom_range(1, 7));
            else if (roll < 70)
            begin
                // walk up with gaps up to six so chains both continue and break
                r[i] = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'(rank);
                step = $urandom_range(0, 6);
                if (rank + step <= 7)
                    rank = rank + step;
            end
            else
                r[i] = 3'($urandom_range(0, 7));
        end
        return {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7]};
    endfunction

    function automatic int idle_gap();
        int roll;
        if (calm_items > 0)
        begin
            calm_items--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
            calm_items = $urandom_range(20, 80);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic offer_ranks(input item_t ranks, input result_t want);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= ranks;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_routes.push_back(want);
        beats_taken++;
    endtask

    initial
    begin : item_side
        item_t   ranks;
        result_t want;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (route_cases[n])
        begin
            want = route_cases[n].known ? route_cases[n].golden
                                        : route_ranks(route_cases[n].stim);
            offer_ranks(route_cases[n].stim, want);
        end
        repeat (ROUTE_ITEMS - ROUTE_CASES)
        begin
            ranks = random_ranks();
            offer_ranks(ranks, route_ranks(ranks));
        end
        item_valid <= 1'b0;
        while (pending_routes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("rank_chain_crosspoint_router_unit_test OK");
        else
            $display("rank_chain_crosspoint_router_unit_test NOT OK");
        $finish;
    end

    initial
    begin : result_side
        int hold_left;
        int calm_left;
        int roll;
        hold_left = 0;
        calm_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!squeezed && beats_taken >= 500)
            begin
                // long hold-off so the pipe fills and pushes back on the item side
                squeezed = 1'b1;
                result_stall <= 1'b1;
                repeat (120) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                result_stall <= 1'b0;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    result_stall <= 1'b0;
                else if (roll < 90)
                begin
                    result_stall <= 1'b1;
                    hold_left = $urandom_range(0, 2);
                end
                else if (roll < 95)
                begin
                    result_stall <= 1'b1;
                    hold_left = $urandom_range(10, 40);
                end
                else
                begin
                    result_stall <= 1'b0;
                    calm_left = $urandom_range(30, 150);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_routes.size() == 0)
            begin
                $error("result beat with nothing expected: connect_mask %h bypass %b",
                       result.connect_mask, result.bypass);
                mismatches++;
            end
            else
            begin
                if (result.connect_mask !== pending_routes[0].connect_mask)
                begin
                    $error("connect_mask: expected %h, got %h",
                           pending_routes[0].connect_mask, result.connect_mask);
                    mismatches++;
                end
                if (result.bypass !== pending_routes[0].bypass)
                begin
                    $error("bypass: expected %b, got %b",
                           pending_routes[0].bypass, result.bypass);
                    mismatches++;
                end
                void'(pending_routes.pop_front());
            end
        end
    end

    initial
    begin : watchdog
        #20ms;
        $display("rank_chain_crosspoint_router_unit_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
